// File: rtl/bmq_pkg.sv
// Shared constants, types and helpers for the block mean quantizer.
// No dependencies; every other file refers to it by scoped names.
package bmq_pkg;

	// Frame and block limits
	localparam int MAX_WIDTH = 640;
	localparam int MAX_BLOCK = 64;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);

	// Field widths
	localparam int PIX_W  = 8;
	localparam int CODE_W = 3;
	localparam int BS_W   = 7;
	localparam int FW_W   = 10;
	localparam int FH_W   = 9;
	localparam int OFS_W  = 6;
	localparam int SUM_W  = 20;
	localparam int BB_W   = 2 * BS_W - 1;
	localparam int Q_W    = 9;
	localparam int CFG_W  = 10;
	localparam int CFG_IDX_W = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	// Register reset values
	localparam logic [BS_W-1:0] BLOCK_SIZE_RST   = 7'd5;
	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 10'd480;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 9'd360;

	// Level thresholds, lowest first
	localparam int N_THR = 6;
	localparam logic [N_THR-1:0][PIX_W-1:0] LVL_THR =
		{8'd175, 8'd145, 8'd115, 8'd90, 8'd60, 8'd30};
	localparam logic [CODE_W-1:0] LVL_ZERO  = 3'd0;
	localparam logic [CODE_W-1:0] LVL_FIRST = 3'd1;

	// Controller to datapath commands
	typedef struct packed {
		logic clr_step;
		logic accept;
		logic div_row;
		logic eval;
		logic div_mean;
		logic load_out;
	} bmq_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic blk_done;
		logic out_free;
	} bmq_sts_t;

	// Eight-level code of a block mean
	function automatic logic [CODE_W-1:0] level_of(input logic [PIX_W-1:0] m);
		logic [CODE_W-1:0] code;
		code = LVL_FIRST;
		for (int i = 0; i < N_THR; i++) begin
			if (m >= LVL_THR[i]) code = code + 3'd1;
		end
		if (m == '0) code = LVL_ZERO;
		return code;
	endfunction

endpackage

// File: rtl/bmq_pix_if.sv
// Pixel input channel: valid/ready handshake with brightness payload.
// Depends on bmq_pkg for field widths.
interface bmq_pix_if;
	logic                      valid;
	logic                      ready;
	logic [bmq_pkg::PIX_W-1:0] brightness;
	logic                      start_of_frame;

	modport source (output valid, brightness, start_of_frame, input ready);
	modport sink   (input valid, brightness, start_of_frame, output ready);
endinterface

// File: rtl/bmq_res_if.sv
// Block result channel: valid/ready handshake with mean, code and position.
// Depends on bmq_pkg for field widths.
interface bmq_res_if;
	logic                       valid;
	logic                       ready;
	logic [bmq_pkg::PIX_W-1:0]  block_mean;
	logic [bmq_pkg::CODE_W-1:0] level_code;
	logic [bmq_pkg::FW_W-1:0]   block_column;
	logic [bmq_pkg::FH_W-1:0]   block_row;
	logic                       last_of_frame;

	modport source (output valid, block_mean, level_code, block_column, block_row,
		last_of_frame, input ready);
	modport sink   (input valid, block_mean, level_code, block_column, block_row,
		last_of_frame, output ready);
endinterface

// File: rtl/bmq_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturates to all ones.
// Depends on bmq_pkg for widths.
module bmq_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bmq_pkg::SUM_W-1:0]   dividend,
	input  logic [bmq_pkg::BB_W-1:0]    divisor,
	output logic                        done,
	output logic [bmq_pkg::Q_W-1:0]     quot
);
	localparam int DSH_W  = bmq_pkg::BB_W + bmq_pkg::Q_W;
	localparam int STEP_W = $clog2(bmq_pkg::Q_W + 1);

	logic                       busy_q;
	logic [STEP_W-1:0]          step_q;
	logic [bmq_pkg::SUM_W-1:0]  rem_q;
	logic [DSH_W-1:0]           dsh_q;
	logic [bmq_pkg::Q_W-1:0]    quot_q;
	logic                       ovf_q;
	logic                       ge;

	assign ge   = DSH_W'(rem_q) >= dsh_q;
	assign done = busy_q && (step_q == STEP_W'(bmq_pkg::Q_W));
	assign quot = ovf_q ? '1 : quot_q;

	// step 0 checks for overflow, steps 1..Q_W produce quotient bits msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (done) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= {divisor, {bmq_pkg::Q_W{1'b0}}};
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dsh_q <= dsh_q >> 1;
			if (step_q == '0) begin
				ovf_q <= ge;
			end else begin
				quot_q <= {quot_q[bmq_pkg::Q_W-2:0], ge};
				if (ge) rem_q <= rem_q - dsh_q[bmq_pkg::SUM_W-1:0];
			end
		end
	end
endmodule

// File: rtl/bmq_datapath.sv
// Datapath: config registers, position counters, column sum memory,
// edge-block checks, shared divider and the result register.
// Depends on bmq_pkg and bmq_div.
module bmq_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bmq_pkg::bmq_cmd_t                 cmd,
	output bmq_pkg::bmq_sts_t                 sts,
	input  logic                              cfg_we,
	input  logic [bmq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bmq_pkg::CFG_W-1:0]         cfg_data,
	input  logic [bmq_pkg::PIX_W-1:0]         brightness,
	input  logic                              start_of_frame,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [bmq_pkg::PIX_W-1:0]         block_mean,
	output logic [bmq_pkg::CODE_W-1:0]        level_code,
	output logic [bmq_pkg::FW_W-1:0]          block_column,
	output logic [bmq_pkg::FH_W-1:0]          block_row,
	output logic                              last_of_frame
);
	localparam int BS_W  = bmq_pkg::BS_W;
	localparam int FW_W  = bmq_pkg::FW_W;
	localparam int FH_W  = bmq_pkg::FH_W;
	localparam int OFS_W = bmq_pkg::OFS_W;
	localparam int SUM_W = bmq_pkg::SUM_W;
	localparam int AW    = bmq_pkg::ADDR_W;
	localparam int Q_W   = bmq_pkg::Q_W;
	localparam int CP_W  = FW_W + BS_W + 1;
	localparam int RP_W  = Q_W + BS_W + 1;
	localparam int PIX_W_L = bmq_pkg::PIX_W;

	// configuration registers
	logic [BS_W-1:0] block_size_q;
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= bmq_pkg::BLOCK_SIZE_RST;
			frame_width_q  <= bmq_pkg::FRAME_WIDTH_RST;
			frame_height_q <= bmq_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bmq_pkg::REG_BLOCK_SIZE:   block_size_q   <= cfg_data[BS_W-1:0];
				bmq_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				bmq_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// effective (clamped) settings
	logic [BS_W-1:0] eb;
	logic [FW_W-1:0] ew;
	logic [FH_W-1:0] eh;
	logic [bmq_pkg::BB_W-1:0] bb;

	always_comb begin
		if (block_size_q == '0) eb = BS_W'(1);
		else if (int'(block_size_q) > bmq_pkg::MAX_BLOCK) eb = BS_W'(bmq_pkg::MAX_BLOCK);
		else eb = block_size_q;
		if (frame_width_q == '0) ew = FW_W'(1);
		else if (int'(frame_width_q) > bmq_pkg::MAX_WIDTH) ew = FW_W'(bmq_pkg::MAX_WIDTH);
		else ew = frame_width_q;
		eh = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
	end
	assign bb = bmq_pkg::BB_W'(eb * eb);

	// position counters
	logic [FW_W-1:0]  pcol_q;
	logic [FH_W-1:0]  prow_q;
	logic [OFS_W-1:0] offx_q;
	logic [OFS_W-1:0] offy_q;
	logic [FW_W-1:0]  bcol_q;
	logic [PIX_W_L-1:0] pix_q;

	logic [FW_W:0]    pcol_inc;
	logic [FH_W:0]    prow_inc;
	logic [OFS_W:0]   offx_inc;
	logic [OFS_W:0]   offy_inc;

	assign pcol_inc = {1'b0, pcol_q} + (FW_W+1)'(1);
	assign prow_inc = {1'b0, prow_q} + (FH_W+1)'(1);
	assign offx_inc = {1'b0, offx_q} + (OFS_W+1)'(1);
	assign offy_inc = {1'b0, offy_q} + (OFS_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcol_q <= '0;
			prow_q <= '0;
			offx_q <= '0;
			offy_q <= '0;
			bcol_q <= '0;
		end else if (cmd.accept && start_of_frame) begin
			pcol_q <= '0;
			prow_q <= '0;
			offx_q <= '0;
			offy_q <= '0;
			bcol_q <= '0;
		end else if (cmd.eval) begin
			if (pcol_inc >= {1'b0, ew}) begin
				pcol_q <= '0;
				offx_q <= '0;
				bcol_q <= '0;
				if (prow_inc >= {1'b0, eh}) begin
					prow_q <= '0;
					offy_q <= '0;
				end else begin
					prow_q <= prow_inc[FH_W-1:0];
					offy_q <= (offy_inc >= eb) ? '0 : offy_inc[OFS_W-1:0];
				end
			end else begin
				pcol_q <= pcol_inc[FW_W-1:0];
				if (offx_inc >= eb) begin
					offx_q <= '0;
					bcol_q <= bcol_q + FW_W'(1);
				end else begin
					offx_q <= offx_inc[OFS_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) pix_q <= brightness;
	end

	// column checks from the counters, settled while the row divide runs
	logic [CP_W-1:0] col_prod;
	logic            col_ok_q;
	logic            col_last_q;

	assign col_prod = CP_W'(bcol_q * eb);

	always_ff @(posedge clk) begin
		col_ok_q   <= (col_prod + CP_W'(eb)) <= CP_W'(ew);
		col_last_q <= (col_prod + CP_W'({eb, 1'b0})) > CP_W'(ew);
	end

	// shared divider: block row first, then the block mean
	logic [Q_W-1:0]   quot;
	logic             div_done;
	logic [SUM_W-1:0] sum_q;

	bmq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_row || cmd.div_mean),
		.dividend (cmd.div_mean ? sum_q : SUM_W'(prow_q)),
		.divisor  (cmd.div_mean ? bb : bmq_pkg::BB_W'(eb)),
		.done     (div_done),
		.quot     (quot)
	);

	// row checks from the quotient
	logic [RP_W-1:0] row_prod;
	logic            row_ok;
	logic            row_last;

	assign row_prod = RP_W'(quot * eb);
	assign row_ok   = (row_prod + RP_W'(eb)) <= RP_W'(eh);
	assign row_last = (row_prod + RP_W'({eb, 1'b0})) > RP_W'(eh);

	// column sum memory, cleared by a sweep after reset
	logic [SUM_W-1:0] mem [bmq_pkg::MAX_WIDTH];
	logic [SUM_W-1:0] rd_q;
	logic [AW-1:0]    clr_addr_q;
	logic [AW-1:0]    col_addr;
	logic [SUM_W-1:0] sum;
	logic             hit;
	logic             first_px;

	assign col_addr = AW'(bcol_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_addr_q <= '0;
		else if (cmd.clr_step) clr_addr_q <= clr_addr_q + AW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) mem[clr_addr_q] <= '0;
		else if (cmd.eval && hit) mem[col_addr] <= sum;
		rd_q <= mem[col_addr];
	end

	// accumulate and detect block completion
	assign first_px = (offx_q == '0) && (offy_q == '0);
	assign sum      = (first_px ? '0 : rd_q) + SUM_W'(pix_q);
	assign hit      = col_ok_q && row_ok && (int'(bcol_q) < bmq_pkg::MAX_WIDTH)
		&& (pcol_q < ew) && (prow_q < eh);

	// result position held until the mean is ready
	logic [FW_W-1:0] res_col_q;
	logic [FH_W-1:0] res_row_q;
	logic            res_last_q;

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			sum_q      <= sum;
			res_col_q  <= bcol_q;
			res_row_q  <= quot;
			res_last_q <= col_last_q && row_last;
		end
	end

	// output register
	logic            out_valid_q;
	logic [PIX_W_L-1:0] mean;

	assign mean = quot[Q_W-1] ? '1 : quot[PIX_W_L-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load_out) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			block_mean    <= mean;
			level_code    <= bmq_pkg::level_of(mean);
			block_column  <= res_col_q;
			block_row     <= res_row_q;
			last_of_frame <= res_last_q;
		end
	end

	assign out_valid = out_valid_q;

	// status to the controller
	assign sts.clr_last = clr_addr_q == AW'(bmq_pkg::MAX_WIDTH - 1);
	assign sts.div_done = div_done;
	assign sts.blk_done = hit && (BS_W'(offx_q) == eb - BS_W'(1))
		&& (BS_W'(offy_q) == eb - BS_W'(1));
	assign sts.out_free = !out_valid_q || out_ready;
endmodule

// File: rtl/bmq_ctrl.sv
// Controller: sequences the memory clear, the row divide, the accumulate
// step, the mean divide and the result hand-off. Depends on bmq_pkg.
module bmq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bmq_pkg::bmq_sts_t sts,
	output bmq_pkg::bmq_cmd_t cmd
);
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_ROW   = 3'd2;
	localparam logic [2:0] S_ROWW  = 3'd3;
	localparam logic [2:0] S_EVAL  = 3'd4;
	localparam logic [2:0] S_MEAN  = 3'd5;
	localparam logic [2:0] S_MEANW = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nx   = S_ROW;
				end
			end
			S_ROW: begin
				cmd.div_row = 1'b1;
				state_nx    = S_ROWW;
			end
			S_ROWW: begin
				if (sts.div_done) state_nx = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_nx = sts.blk_done ? S_MEAN : S_IDLE;
			end
			S_MEAN: begin
				cmd.div_mean = 1'b1;
				state_nx     = S_MEANW;
			end
			S_MEANW: begin
				if (sts.div_done) state_nx = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_nx;
	end
endmodule

// File: rtl/block_mean_quantizer_core.sv
// Top level of the block mean quantizer: controller plus datapath.
// Depends on bmq_pkg, bmq_pix_if, bmq_res_if, bmq_ctrl and bmq_datapath.
//
//  port    dir   kind          word
//  pix     in    valid/ready   brightness, start_of_frame
//  res     out   valid/ready   block_mean, level_code, block_column, block_row,
//                              last_of_frame
//  cfg_*   in    write only    cfg_index selects the register, cfg_data the value
//
// A pixel has its block row divided, then its sum added in one accumulate
// step; one that completes a block then has its mean divided and waits for
// the result register. Both divides use the shared divider (block row, then
// block mean). After reset a sweep clears the column sum memory; pixels are
// not taken until it ends, config writes are. A stalled result holds in the
// output register while the next pixel is accepted.
module block_mean_quantizer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	bmq_pix_if.sink                       pix,
	bmq_res_if.source                     res,
	input  logic                          cfg_we,
	input  logic [bmq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bmq_pkg::CFG_W-1:0]     cfg_data
);
	bmq_pkg::bmq_cmd_t cmd;
	bmq_pkg::bmq_sts_t sts;

	bmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (pix.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmq_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.brightness     (pix.brightness),
		.start_of_frame (pix.start_of_frame),
		.out_ready      (res.ready),
		.out_valid      (res.valid),
		.block_mean     (res.block_mean),
		.level_code     (res.level_code),
		.block_column   (res.block_column),
		.block_row      (res.block_row),
		.last_of_frame  (res.last_of_frame)
	);
endmodule
